>>> hw/rtl/dfpu_pkg.sv
// ----------------------------------------------------------------------------
// dfpu_pkg: shared types and constants of the double FP add/convert/compare ALU
// Opcode values, the decoded operation class, the work item passed from the
// front queue to the execution pipeline, and the result record.
// ----------------------------------------------------------------------------
package dfpu_pkg;

   // Opcodes; the second name of each pair is its immediate alias
   localparam logic [6:0] CMD_ADD      = 7'h1E;
   localparam logic [6:0] CMD_ADD_I    = 7'h23;
   localparam logic [6:0] CMD_SUB      = 7'h1F;
   localparam logic [6:0] CMD_SUB_I    = 7'h24;
   localparam logic [6:0] CMD_CPYSGN   = 7'h22;
   localparam logic [6:0] CMD_CPYSGN_I = 7'h27;
   localparam logic [6:0] CMD_NEG      = 7'h29;
   localparam logic [6:0] CMD_NEG_I    = 7'h53;
   localparam logic [6:0] CMD_ABS      = 7'h2A;
   localparam logic [6:0] CMD_ABS_I    = 7'h54;
   localparam logic [6:0] CMD_F2I      = 7'h2B;
   localparam logic [6:0] CMD_F2I_I    = 7'h55;
   localparam logic [6:0] CMD_I2F      = 7'h2C;
   localparam logic [6:0] CMD_I2F_I    = 7'h56;
   localparam logic [6:0] CMD_RNE      = 7'h2D;
   localparam logic [6:0] CMD_RNE_I    = 7'h57;
   localparam logic [6:0] CMD_RNE2     = 7'h30;
   localparam logic [6:0] CMD_RNE2_I   = 7'h5A;
   localparam logic [6:0] CMD_RTZ      = 7'h2E;
   localparam logic [6:0] CMD_RTZ_I    = 7'h58;
   localparam logic [6:0] CMD_RUP      = 7'h2F;
   localparam logic [6:0] CMD_RUP_I    = 7'h59;
   localparam logic [6:0] CMD_CMP      = 7'h3F;
   localparam logic [6:0] CMD_CMP_I    = 7'h42;
   localparam logic [6:0] CMD_CMPSUM   = 7'h40;
   localparam logic [6:0] CMD_CMPSUM_I = 7'h43;
   localparam logic [6:0] CMD_CMPABS   = 7'h41;
   localparam logic [6:0] CMD_CMPABS_I = 7'h44;

   // binary64 / int64 bit patterns
   localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] INT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT_MIN   = 64'h8000_0000_0000_0000;
   localparam logic [10:0] EXP_MAX   = 11'h7FF;

   // queue depths
   localparam int FRONT_DEPTH = 4;
   localparam int OUTQ_DEPTH  = 4;
   localparam int FQ_PTR_BITS = $clog2(FRONT_DEPTH);
   localparam int OQ_PTR_BITS = $clog2(OUTQ_DEPTH);
   localparam int OQ_CNT_BITS = OQ_PTR_BITS + 1;

   typedef enum logic [3:0] {
      OP_NONE, OP_ADD, OP_SUB, OP_CPYSGN, OP_NEG, OP_ABS, OP_F2I, OP_I2F,
      OP_RNE, OP_RTZ, OP_RUP, OP_CMP, OP_CMPSUM, OP_CMPABS
   } op_class_type;

   typedef struct packed {
      op_class_type op;
      logic [63:0]  a;
      logic [63:0]  b;
      logic         a_nan;
      logic         b_nan;
   } work_item_type;

   typedef struct packed {
      logic [63:0] value;
      logic        invalid;
      logic [3:0]  nzcv;
      logic        fvalid;
   } result_type;

   function automatic logic fp_is_nan(input logic [63:0] x);
      return (x[62:52] == EXP_MAX) && (x[51:0] != 52'd0);
   endfunction

endpackage

>>> hw/rtl/dfpu_front.sv
// ----------------------------------------------------------------------------
// dfpu_front: opcode decode and input queue
// Classifies each incoming item (operation class, NaN operands) and holds it
// in a short queue until the execution pipeline takes it.
// ----------------------------------------------------------------------------
module dfpu_front #(
   parameter int TAG_BITS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [6:0]              req_cmd,
   input  logic [63:0]             req_operand_a,
   input  logic [63:0]             req_operand_b,
   input  logic [TAG_BITS-1:0]     req_dest_tag,
   output logic                    head_valid,
   output dfpu_pkg::work_item_type head_item,
   output logic [TAG_BITS-1:0]     head_tag,
   input  logic                    head_pop
);
   import dfpu_pkg::*;

   work_item_type           mem_ff [FRONT_DEPTH];
   logic [TAG_BITS-1:0]     tag_ff [FRONT_DEPTH];
   logic [FQ_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FQ_PTR_BITS:0]    count_ff, count_in;
   logic                    push_ok, pop_ok;
   work_item_type           dec_item;
   op_class_type            dec_op;

   // opcode classification, aliases fold together
   always_comb begin
      case (req_cmd)
         CMD_ADD, CMD_ADD_I:                        dec_op = OP_ADD;
         CMD_SUB, CMD_SUB_I:                        dec_op = OP_SUB;
         CMD_CPYSGN, CMD_CPYSGN_I:                  dec_op = OP_CPYSGN;
         CMD_NEG, CMD_NEG_I:                        dec_op = OP_NEG;
         CMD_ABS, CMD_ABS_I:                        dec_op = OP_ABS;
         CMD_F2I, CMD_F2I_I:                        dec_op = OP_F2I;
         CMD_I2F, CMD_I2F_I:                        dec_op = OP_I2F;
         CMD_RNE, CMD_RNE_I, CMD_RNE2, CMD_RNE2_I:  dec_op = OP_RNE;
         CMD_RTZ, CMD_RTZ_I:                        dec_op = OP_RTZ;
         CMD_RUP, CMD_RUP_I:                        dec_op = OP_RUP;
         CMD_CMP, CMD_CMP_I:                        dec_op = OP_CMP;
         CMD_CMPSUM, CMD_CMPSUM_I:                  dec_op = OP_CMPSUM;
         CMD_CMPABS, CMD_CMPABS_I:                  dec_op = OP_CMPABS;
         default:                                   dec_op = OP_NONE;
      endcase
      dec_item.op    = dec_op;
      dec_item.a     = req_operand_a;
      dec_item.b     = req_operand_b;
      dec_item.a_nan = fp_is_nan(req_operand_a);
      dec_item.b_nan = fp_is_nan(req_operand_b);
   end

   // queue control
   assign req_full   = (count_ff == (FQ_PTR_BITS+1)'(FRONT_DEPTH));
   assign head_valid = (count_ff != '0);
   assign push_ok    = req_push & ~req_full;
   assign pop_ok     = head_pop & head_valid;
   assign wr_ptr_in  = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in  = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in   = count_ff + (FQ_PTR_BITS+1)'(push_ok) - (FQ_PTR_BITS+1)'(pop_ok);

   assign head_item = mem_ff[rd_ptr_ff];
   assign head_tag  = tag_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= dec_item;
         tag_ff[wr_ptr_ff] <= req_dest_tag;
      end
   end

   a_front_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FQ_PTR_BITS+1)'(FRONT_DEPTH))
      else $error("front queue count beyond depth");

endmodule

>>> hw/rtl/dfpu_exec.sv
// ----------------------------------------------------------------------------
// dfpu_exec: three-stage execution pipeline
// Stage 1 aligns adder operands and does the bitwise ops, conversions to int,
// rounding to integral and compares; stage 2 adds and counts leading zeros;
// stage 3 normalizes, rounds to nearest-even and packs the result.
// ----------------------------------------------------------------------------
module dfpu_exec #(
   parameter int TAG_BITS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  dfpu_pkg::work_item_type      in_item,
   input  logic [TAG_BITS-1:0]          in_tag,
   output logic                         in_pop,
   input  logic [dfpu_pkg::OQ_CNT_BITS-1:0] out_count,
   output logic                         out_push,
   output dfpu_pkg::result_type         out_result,
   output logic [TAG_BITS-1:0]          out_tag
);
   import dfpu_pkg::*;

   typedef struct packed {
      op_class_type        op;
      logic                sign_l;
      logic                eff_sub;
      logic [10:0]         el;
      logic [55:0]         large_sig;
      logic [55:0]         small_sig;
      logic                zero_sign;
      logic                special;
      logic [63:0]         special_val;
      logic                i_sign;
      logic [63:0]         i_mag;
      logic [63:0]         direct;
      logic [3:0]          nzcv;
      logic                a_nan;
      logic                b_nan;
      logic [TAG_BITS-1:0] tag;
   } p1_type;

   typedef struct packed {
      op_class_type        op;
      logic [63:0]         m;
      logic [11:0]         e;
      logic [6:0]          sh;
      logic                sign;
      logic                special;
      logic [63:0]         special_val;
      logic [63:0]         direct;
      logic [3:0]          nzcv;
      logic                a_nan;
      logic                b_nan;
      logic [TAG_BITS-1:0] tag;
   } p2_type;

   p1_type p1_ff, p1_in;
   p2_type p2_ff, p2_in;
   logic   p1_v_ff, p2_v_ff;
   logic [OQ_CNT_BITS:0] credit_used;

   // round to integral value
   function automatic logic [63:0] round_int(input logic [63:0] x, input op_class_type op);
      logic [10:0] e;
      logic        neg;
      logic [5:0]  fb;
      logic [63:0] unit, mask, frac, tr, half, r;
      e    = x[62:52];
      neg  = x[63];
      fb   = 6'(11'd1075 - e);
      unit = 64'd1 << fb;
      mask = unit - 64'd1;
      frac = x & mask;
      tr   = x & ~mask;
      half = unit >> 1;
      if (e == EXP_MAX || e >= 11'd1075) r = x;
      else if (e < 11'd1023) begin
         if (x[62:0] == 63'd0) r = x;
         else if (op == OP_RTZ) r = {neg, 63'd0};
         else if (op == OP_RUP) r = neg ? {1'b1, 63'd0} : ONE_BITS;
         else if (e == 11'd1022 && x[51:0] != 52'd0) r = {neg, 63'd0} | ONE_BITS;
         else r = {neg, 63'd0};
      end else if (frac == 64'd0 || op == OP_RTZ) r = tr;
      else if (op == OP_RUP) r = neg ? tr : tr + unit;
      else if (frac > half || (frac == half && (x & unit) != 64'd0)) r = tr + unit;
      else r = tr;
      return r;
   endfunction

   // truncating, saturating conversion to int64
   function automatic logic [63:0] to_int(input logic [63:0] x, input logic x_nan);
      logic [10:0] e;
      logic [63:0] sig, mag, r;
      logic [5:0]  lsh, rsh;
      e   = x[62:52];
      sig = {11'd0, 1'b1, x[51:0]};
      lsh = 6'(e - 11'd1075);
      rsh = 6'(11'd1075 - e);
      mag = (e >= 11'd1075) ? (sig << lsh) : (sig >> rsh);
      if (x_nan) r = 64'd0;
      else if (e >= 11'd1086) r = x[63] ? INT_MIN : INT_MAX;
      else if (e < 11'd1023) r = 64'd0;
      else r = x[63] ? (64'd0 - mag) : mag;
      return r;
   endfunction

   // issue when the result queue has room for everything in flight
   assign credit_used = (OQ_CNT_BITS+1)'(out_count) + (OQ_CNT_BITS+1)'(p1_v_ff)
                      + (OQ_CNT_BITS+1)'(p2_v_ff);
   assign in_pop = in_valid && (credit_used < (OQ_CNT_BITS+1)'(OUTQ_DEPTH));

   // ---- stage 1 ----
   logic        sa, sb, sb_eff, a_inf, b_inf, swap, ss, both_zero, unord, lt, eq;
   logic [10:0] ea_eff, eb_eff, es, d;
   logic [52:0] ma, mb, ms;
   logic [55:0] sm_ext, sm_shift;
   logic        sm_lost;

   always_comb begin
      sa     = in_item.a[63];
      sb     = in_item.b[63];
      sb_eff = sb ^ (in_item.op == OP_SUB);
      ea_eff = (in_item.a[62:52] == 11'd0) ? 11'd1 : in_item.a[62:52];
      eb_eff = (in_item.b[62:52] == 11'd0) ? 11'd1 : in_item.b[62:52];
      ma     = {in_item.a[62:52] != 11'd0, in_item.a[51:0]};
      mb     = {in_item.b[62:52] != 11'd0, in_item.b[51:0]};
      a_inf  = (in_item.a[62:52] == EXP_MAX) && (in_item.a[51:0] == 52'd0);
      b_inf  = (in_item.b[62:52] == EXP_MAX) && (in_item.b[51:0] == 52'd0);
      swap   = in_item.b[62:0] > in_item.a[62:0];
      ss     = swap ? sa : sb_eff;
      es     = swap ? ea_eff : eb_eff;
      ms     = swap ? ma : mb;

      p1_in.op        = in_item.op;
      p1_in.sign_l    = swap ? sb_eff : sa;
      p1_in.el        = swap ? eb_eff : ea_eff;
      p1_in.large_sig = {(swap ? mb : ma), 3'b000};
      p1_in.eff_sub   = p1_in.sign_l ^ ss;
      p1_in.zero_sign = sa & sb_eff;

      // align the smaller operand, sticky into bit 0
      d        = p1_in.el - es;
      sm_ext   = {ms, 3'b000};
      sm_shift = sm_ext >> d;
      sm_lost  = (sm_ext & ((56'd1 << d) - 56'd1)) != 56'd0;
      if (d >= 11'd56) p1_in.small_sig = {55'd0, ms != 53'd0};
      else p1_in.small_sig = sm_shift | {55'd0, sm_lost};

      // adder special operands
      p1_in.special     = 1'b1;
      p1_in.special_val = QNAN_BITS;
      if (in_item.a_nan || in_item.b_nan || (a_inf && b_inf && (sa != sb_eff)))
         p1_in.special_val = QNAN_BITS;
      else if (a_inf) p1_in.special_val = {sa, EXP_MAX, 52'd0};
      else if (b_inf) p1_in.special_val = {sb_eff, EXP_MAX, 52'd0};
      else p1_in.special = 1'b0;

      // int64 to double magnitude
      p1_in.i_sign = sb;
      p1_in.i_mag  = sb ? (64'd0 - in_item.b) : in_item.b;

      // compares
      unord     = in_item.a_nan | in_item.b_nan;
      both_zero = (in_item.a[62:0] == 63'd0) && (in_item.b[62:0] == 63'd0);
      if (in_item.op == OP_CMPABS) begin
         eq = in_item.a[62:0] == in_item.b[62:0];
         lt = in_item.a[62:0] < in_item.b[62:0];
      end else begin
         eq = (in_item.a == in_item.b) || both_zero;
         if (sa != sb) lt = sa & ~both_zero;
         else if (!sa) lt = in_item.a[62:0] < in_item.b[62:0];
         else lt = in_item.a[62:0] > in_item.b[62:0];
      end
      p1_in.nzcv = unord ? 4'b0001 : {lt, eq, ~lt, 1'b0};

      // results that need no adder
      case (in_item.op)
         OP_CPYSGN:                p1_in.direct = {sb, in_item.a[62:0]};
         OP_NEG:                   p1_in.direct = {~sb, in_item.b[62:0]};
         OP_ABS:                   p1_in.direct = {1'b0, in_item.b[62:0]};
         OP_F2I:                   p1_in.direct = to_int(in_item.b, in_item.b_nan);
         OP_RNE, OP_RTZ, OP_RUP:   p1_in.direct = round_int(in_item.b, in_item.op);
         default:                  p1_in.direct = 64'd0;
      endcase

      p1_in.a_nan = in_item.a_nan;
      p1_in.b_nan = in_item.b_nan;
      p1_in.tag   = in_tag;
   end

   // ---- stage 2: add and leading-zero count ----
   logic [56:0] sum;
   logic [6:0]  lz;
   logic [11:0] shift_lim;

   always_comb begin
      sum = p1_ff.eff_sub ? ({1'b0, p1_ff.large_sig} - {1'b0, p1_ff.small_sig})
                          : ({1'b0, p1_ff.large_sig} + {1'b0, p1_ff.small_sig});
      if (p1_ff.op == OP_I2F) begin
         p2_in.m    = p1_ff.i_mag;
         p2_in.e    = 12'd1086;
         p2_in.sign = p1_ff.i_sign;
      end else begin
         p2_in.m    = {sum, 7'd0};
         p2_in.e    = {1'b0, p1_ff.el} + 12'd1;
         p2_in.sign = (sum == 57'd0) ? p1_ff.zero_sign : p1_ff.sign_l;
      end
      lz = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (p2_in.m[i]) lz = 7'(63 - i);
      end
      // stop at the subnormal boundary
      shift_lim = p2_in.e - 12'd1;
      p2_in.sh  = ({5'd0, lz} < shift_lim) ? lz : shift_lim[6:0];

      p2_in.op          = p1_ff.op;
      p2_in.special     = p1_ff.special;
      p2_in.special_val = p1_ff.special_val;
      p2_in.direct      = p1_ff.direct;
      p2_in.nzcv        = p1_ff.nzcv;
      p2_in.a_nan       = p1_ff.a_nan;
      p2_in.b_nan       = p1_ff.b_nan;
      p2_in.tag         = p1_ff.tag;
   end

   // ---- stage 3: normalize, round, pack ----
   logic [63:0] mn, add_res, value;
   logic [11:0] en;
   logic [10:0] efield;
   logic [62:0] packed_val;
   logic        rnd_up, zero_sum;

   always_comb begin
      mn         = p2_ff.m << p2_ff.sh;
      en         = p2_ff.e - {5'd0, p2_ff.sh};
      efield     = mn[63] ? en[10:0] : 11'd0;
      rnd_up     = mn[10] & ((mn[9:0] != 10'd0) | mn[11]);
      packed_val = {efield, mn[62:11]} + {62'd0, rnd_up};
      // int64 operand bits are never special floating-point values
      if (p2_ff.special && p2_ff.op != OP_I2F) add_res = p2_ff.special_val;
      else if (mn[63] && en >= 12'd2047) add_res = {p2_ff.sign, EXP_MAX, 52'd0};
      else add_res = {p2_ff.sign, packed_val};
      zero_sum = add_res[62:0] == 63'd0;

      out_result.nzcv   = 4'd0;
      out_result.fvalid = 1'b0;
      case (p2_ff.op)
         OP_ADD, OP_SUB, OP_I2F: value = add_res;
         OP_CMP, OP_CMPABS: begin
            value             = 64'd0;
            out_result.nzcv   = p2_ff.nzcv;
            out_result.fvalid = 1'b1;
         end
         OP_CMPSUM: begin
            value             = 64'd0;
            out_result.fvalid = 1'b1;
            if (p2_ff.a_nan || p2_ff.b_nan) out_result.nzcv = 4'b0001;
            else if (fp_is_nan(add_res)) out_result.nzcv = 4'b0000;
            else out_result.nzcv = {add_res[63] & ~zero_sum, zero_sum,
                                    ~add_res[63] | zero_sum, 1'b0};
         end
         default: value = p2_ff.direct;
      endcase
      // canonical NaN for every binary64 result
      if (p2_ff.op != OP_F2I && fp_is_nan(value)) value = QNAN_BITS;
      out_result.value   = value;
      out_result.invalid = fp_is_nan(value) & ~p2_ff.a_nan & ~p2_ff.b_nan;
   end

   assign out_push = p2_v_ff;
   assign out_tag  = p2_ff.tag;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= in_pop;
         p2_v_ff <= p1_v_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      p1_ff <= p1_in;
      p2_ff <= p2_in;
   end

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      p1_v_ff |=> p2_v_ff)
      else $error("item lost between stage 1 and stage 2");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_result.fvalid) |-> (out_result.value == 64'd0))
      else $error("compare item with nonzero value");

endmodule

>>> hw/rtl/dfpu_resq.sv
// ----------------------------------------------------------------------------
// dfpu_resq: result queue
// Holds finished items until the consumer pops them; its fill count feeds
// the issue credit of the execution pipeline.
// ----------------------------------------------------------------------------
module dfpu_resq #(
   parameter int TAG_BITS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  dfpu_pkg::result_type             push_result,
   input  logic [TAG_BITS-1:0]              push_tag,
   output logic [dfpu_pkg::OQ_CNT_BITS-1:0] count,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output dfpu_pkg::result_type             head_result,
   output logic [TAG_BITS-1:0]              head_tag
);
   import dfpu_pkg::*;

   result_type              mem_ff [OUTQ_DEPTH];
   logic [TAG_BITS-1:0]     tag_ff [OUTQ_DEPTH];
   logic [OQ_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [OQ_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OQ_CNT_BITS-1:0]  count_ff, count_in;
   logic                    pop_ok;

   assign rsp_empty   = (count_ff == '0);
   assign pop_ok      = rsp_pop & ~rsp_empty;
   assign wr_ptr_in   = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in   = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in    = count_ff + OQ_CNT_BITS'(push) - OQ_CNT_BITS'(pop_ok);
   assign count       = count_ff;
   assign head_result = mem_ff[rd_ptr_ff];
   assign head_tag    = tag_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_result;
         tag_ff[wr_ptr_ff] <= push_tag;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < OQ_CNT_BITS'(OUTQ_DEPTH)))
      else $error("result queue written while full");

endmodule

>>> hw/rtl/double_fp_add_convert_compare_alu.sv
// ----------------------------------------------------------------------------
// double_fp_add_convert_compare_alu: binary64 add / convert / round / compare
// Front queue decodes items, a three-stage pipeline executes them, and a
// result queue hands them out in order.
//
//   channel   ports                                   handshake
//   request   req_cmd, req_operand_a/b, req_dest_tag   req_push / req_full
//   response  rsp_result_value, rsp_invalid_flag,      rsp_pop / rsp_empty
//             rsp_nzcv_flags, rsp_flags_valid,
//             rsp_result_tag
//
// One item per cycle sustained while the consumer pops. An accepted item reaches
// the response side via the front queue, two pipeline registers and result queue.
// Issue into the pipeline waits for room in the four-entry result queue, so a
// stalled consumer fills the result queue and then the four-entry front queue.
// Reset empties both queues and the pipeline.
// ----------------------------------------------------------------------------
module double_fp_add_convert_compare_alu #(
   parameter int TAG_BITS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [6:0]          req_cmd,
   input  logic [63:0]         req_operand_a,
   input  logic [63:0]         req_operand_b,
   input  logic [TAG_BITS-1:0] req_dest_tag,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [63:0]         rsp_result_value,
   output logic                rsp_invalid_flag,
   output logic [3:0]          rsp_nzcv_flags,
   output logic                rsp_flags_valid,
   output logic [TAG_BITS-1:0] rsp_result_tag
);
   import dfpu_pkg::*;

   logic                   head_valid, head_pop, ex_push;
   work_item_type          head_item;
   logic [TAG_BITS-1:0]    head_tag, ex_tag;
   result_type             ex_result, rsp_result;
   logic [OQ_CNT_BITS-1:0] oq_count;

   dfpu_front #(.TAG_BITS(TAG_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_dest_tag  (req_dest_tag),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_tag      (head_tag),
      .head_pop      (head_pop)
   );

   dfpu_exec #(.TAG_BITS(TAG_BITS)) u_exec (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (head_valid),
      .in_item    (head_item),
      .in_tag     (head_tag),
      .in_pop     (head_pop),
      .out_count  (oq_count),
      .out_push   (ex_push),
      .out_result (ex_result),
      .out_tag    (ex_tag)
   );

   dfpu_resq #(.TAG_BITS(TAG_BITS)) u_resq (
      .clock       (clock),
      .reset       (reset),
      .push        (ex_push),
      .push_result (ex_result),
      .push_tag    (ex_tag),
      .count       (oq_count),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .head_result (rsp_result),
      .head_tag    (rsp_result_tag)
   );

   assign rsp_result_value = rsp_result.value;
   assign rsp_invalid_flag = rsp_result.invalid;
   assign rsp_nzcv_flags   = rsp_result.nzcv;
   assign rsp_flags_valid  = rsp_result.fvalid;

endmodule
